@@ hw/rtl/ffra_pkg.sv @@
// Package for the first-fit range allocator.
// Holds the request and result transfer types, status codes and defaults.
// No dependencies.
package ffra_pkg;

    localparam int unsigned MAX_FREE_RANGES_DEF = 16;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;

    localparam int unsigned PADDR_W = 3;
    localparam logic CFG_SEL_CAPACITY = 1'b0;

    typedef struct packed {
        logic        operation;
        logic [31:0] unit_count;
        logic [31:0] release_offset;
    } ffra_req_t;

    typedef struct packed {
        logic [31:0] granted_offset;
        logic [1:0]  status;
    } ffra_rsp_t;

endpackage

@@ hw/rtl/ffra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/first_fit_range_allocator.sv @@
// A zero-unit request is answered from idle without reading the list; an allocate that
// finds no fit falls back to the bump cursor. One request at a time; busy drops in the
// result strobe cycle. The list is streamed one entry a cycle, but for a hold while a
// released range is inserted, from one RAM bank into the other through a shared
// merge/compare unit; the banks swap when a release succeeds or an allocate is served
// from the list. Reset: empty list, cursor 0, capacity 0. Results cannot be stalled.
// Top level of the first-fit range allocator; uses ffra_pkg and ffra_ram.
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_FREE_RANGES = MAX_FREE_RANGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ffra_req_t          request,
    output logic               result_valid,
    output ffra_rsp_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IDX_W = $clog2(MAX_FREE_RANGES);
    localparam int unsigned CNT_W = $clog2(MAX_FREE_RANGES + 1);
    localparam logic [CNT_W-1:0] LIST_MAX = CNT_W'(MAX_FREE_RANGES);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PROC     = 3'd1;
    localparam logic [2:0] S_FLUSH    = 3'd2;
    localparam logic [2:0] S_FIN      = 3'd3;
    localparam logic [2:0] S_BUMP     = 3'd4;
    localparam logic [2:0] S_BUMP_CHK = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      capacity_reg, capacity_next;
    logic [31:0]      bump_reg, bump_next;
    logic [CNT_W-1:0] entries_reg, entries_next;
    logic             bank_reg, bank_next;
    logic             result_valid_reg, result_valid_next;

    logic             op_reg, op_next;
    logic [31:0]      count_reg, count_next;
    logic [31:0]      offset_reg, offset_next;
    logic [32:0]      new_en_reg, new_en_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic             ovf_reg, ovf_next;
    logic             placed_reg, placed_next;
    logic [31:0]      granted_reg, granted_next;
    logic             acc_valid_reg, acc_valid_next;
    logic [31:0]      acc_st_reg, acc_st_next;
    logic [32:0]      acc_en_reg, acc_en_next;
    logic [32:0]      avail_reg, avail_next;
    ffra_rsp_t        result_reg, result_next;

    logic             accept;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             emit;
    logic [63:0]      wdata;
    logic [63:0]      rdata0, rdata1, rdata;
    logic [31:0]      ent_st, ent_len;
    logic [32:0]      ent_en;
    logic [32:0]      rem;
    logic             fit;
    logic             insert_now;
    logic             use_new;
    logic [31:0]      item_st;
    logic [32:0]      item_en;
    logic             merge;
    logic [32:0]      acc_len;
    logic [31:0]      acc_len_sat;
    logic [CNT_W-1:0] idx_plus;
    logic [31:0]      ent_st_adv;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_SEL_CAPACITY) ? capacity_reg : 32'd0;

    assign rdata   = bank_reg ? rdata1 : rdata0;
    assign ent_st  = rdata[63:32];
    assign ent_len = rdata[31:0];
    assign ent_en  = {1'b0, ent_st} + {1'b0, ent_len};
    assign rem     = {1'b0, ent_len} - {1'b0, count_reg};
    assign fit     = !placed_reg && !rem[32];
    assign ent_st_adv = ent_st + count_reg;

    assign insert_now = (state_reg == S_PROC) && (op_reg == OP_RELEASE) && !placed_reg
                        && (ent_st > offset_reg);
    assign use_new    = insert_now || (state_reg == S_FLUSH);
    assign item_st    = use_new ? offset_reg : ent_st;
    assign item_en    = use_new ? new_en_reg : ent_en;
    assign merge      = acc_valid_reg && (acc_en_reg >= {1'b0, item_st});

    assign acc_len     = acc_en_reg - {1'b0, acc_st_reg};
    assign acc_len_sat = acc_len[32] ? 32'hFFFF_FFFF : acc_len[31:0];
    assign idx_plus    = idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        capacity_next     = capacity_reg;
        bump_next         = bump_reg;
        entries_next      = entries_reg;
        bank_next         = bank_reg;
        result_valid_next = 1'b0;
        op_next           = op_reg;
        count_next        = count_reg;
        offset_next       = offset_reg;
        new_en_next       = new_en_reg;
        idx_next          = idx_reg;
        w_next            = w_reg;
        ovf_next          = ovf_reg;
        placed_next       = placed_reg;
        granted_next      = granted_reg;
        acc_valid_next    = acc_valid_reg;
        acc_st_next       = acc_st_reg;
        acc_en_next       = acc_en_reg;
        avail_next        = avail_reg;
        result_next       = result_reg;
        re                = 1'b0;
        raddr             = '0;
        emit              = 1'b0;
        wdata             = {acc_st_reg, acc_len_sat};

        if (psel && penable && pwrite && (paddr[2] == CFG_SEL_CAPACITY))
        begin
            capacity_next = pwdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = request.operation;
                    count_next     = request.unit_count;
                    offset_next    = request.release_offset;
                    new_en_next    = {1'b0, request.release_offset}
                                   + {1'b0, request.unit_count};
                    idx_next       = '0;
                    w_next         = '0;
                    ovf_next       = 1'b0;
                    placed_next    = 1'b0;
                    granted_next   = '0;
                    acc_valid_next = 1'b0;
                    if (request.unit_count == 32'd0)
                    begin
                        result_next.granted_offset = '0;
                        result_next.status         = ST_OK;
                        result_valid_next          = 1'b1;
                    end
                    else if (entries_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = '0;
                        state_next = S_PROC;
                    end
                end
            end

            S_PROC:
            begin
                if (op_reg == OP_ALLOCATE)
                begin
                    emit = 1'b1;
                    wdata = {ent_st, ent_len};
                    if (fit)
                    begin
                        placed_next  = 1'b1;
                        granted_next = ent_st;
                        emit         = (rem[31:0] != 32'd0);
                        wdata        = {ent_st_adv, rem[31:0]};
                    end
                end
                else
                begin
                    if (insert_now)
                    begin
                        placed_next = 1'b1;
                    end
                    if (merge)
                    begin
                        if (item_en > acc_en_reg)
                        begin
                            acc_en_next = item_en;
                        end
                    end
                    else
                    begin
                        emit           = acc_valid_reg;
                        acc_valid_next = 1'b1;
                        acc_st_next    = item_st;
                        acc_en_next    = item_en;
                    end
                end
                if (!insert_now)
                begin
                    idx_next = idx_plus;
                    if (idx_plus == entries_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        re    = 1'b1;
                        raddr = idx_plus[IDX_W-1:0];
                    end
                end
            end

            S_FLUSH:
            begin
                if (op_reg == OP_ALLOCATE)
                begin
                    state_next = S_FIN;
                end
                else if (!placed_reg)
                begin
                    placed_next = 1'b1;
                    if (merge)
                    begin
                        if (item_en > acc_en_reg)
                        begin
                            acc_en_next = item_en;
                        end
                    end
                    else
                    begin
                        emit           = acc_valid_reg;
                        acc_valid_next = 1'b1;
                        acc_st_next    = item_st;
                        acc_en_next    = item_en;
                    end
                end
                else
                begin
                    emit           = acc_valid_reg;
                    acc_valid_next = 1'b0;
                    state_next     = S_FIN;
                end
            end

            S_FIN:
            begin
                if (op_reg == OP_RELEASE)
                begin
                    result_next.granted_offset = '0;
                    result_valid_next          = 1'b1;
                    state_next                 = S_IDLE;
                    if (ovf_reg)
                    begin
                        result_next.status = ST_LIST_FULL;
                    end
                    else
                    begin
                        result_next.status = ST_OK;
                        bank_next          = !bank_reg;
                        entries_next       = w_reg;
                    end
                end
                else if (placed_reg)
                begin
                    result_next.granted_offset = granted_reg;
                    result_next.status         = ST_OK;
                    result_valid_next          = 1'b1;
                    bank_next                  = !bank_reg;
                    entries_next               = w_reg;
                    state_next                 = S_IDLE;
                end
                else
                begin
                    state_next = S_BUMP;
                end
            end

            S_BUMP:
            begin
                avail_next = {1'b0, capacity_reg} - {1'b0, bump_reg};
                state_next = S_BUMP_CHK;
            end

            S_BUMP_CHK:
            begin
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
                if (avail_reg[32] || ({1'b0, count_reg} > avail_reg))
                begin
                    result_next.granted_offset = '0;
                    result_next.status         = ST_NO_SPACE;
                end
                else
                begin
                    result_next.granted_offset = bump_reg;
                    result_next.status         = ST_OK;
                    bump_next                  = bump_reg + count_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            if (w_reg == LIST_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                w_next = w_reg + CNT_W'(1);
            end
        end
    end

    ffra_ram #(
        .WIDTH (64),
        .DEPTH (MAX_FREE_RANGES)
    ) u_bank0 (
        .clk   (clk),
        .we    (emit && (w_reg != LIST_MAX) && bank_reg),
        .waddr (w_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (re && !bank_reg),
        .raddr (raddr),
        .rdata (rdata0)
    );

    ffra_ram #(
        .WIDTH (64),
        .DEPTH (MAX_FREE_RANGES)
    ) u_bank1 (
        .clk   (clk),
        .we    (emit && (w_reg != LIST_MAX) && !bank_reg),
        .waddr (w_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (re && bank_reg),
        .raddr (raddr),
        .rdata (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            capacity_reg     <= '0;
            bump_reg         <= '0;
            entries_reg      <= '0;
            bank_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            capacity_reg     <= capacity_next;
            bump_reg         <= bump_next;
            entries_reg      <= entries_next;
            bank_reg         <= bank_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        count_reg     <= count_next;
        offset_reg    <= offset_next;
        new_en_reg    <= new_en_next;
        idx_reg       <= idx_next;
        w_reg         <= w_next;
        ovf_reg       <= ovf_next;
        placed_reg    <= placed_next;
        granted_reg   <= granted_next;
        acc_valid_reg <= acc_valid_next;
        acc_st_reg    <= acc_st_next;
        acc_en_reg    <= acc_en_next;
        avail_reg     <= avail_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hw/rtl/ffra_checker.sv @@
// Port-level checks for the first-fit range allocator, bound to the top level.
// Uses ffra_pkg.
module ffra_checker
    import ffra_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input ffra_req_t request,
    input logic      result_valid,
    input ffra_rsp_t result
);

    a_zero_count_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.unit_count == 32'd0)
        |=> result_valid && (result.status == ST_OK) && (result.granted_offset == 32'd0))
        else $error("zero-unit request not answered at once");

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start))
        else $error("result transfer without a request");

    a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |-> (result.granted_offset == 32'd0))
        else $error("failed request carries an offset");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == ST_OK) || (result.status == ST_NO_SPACE)
                         || (result.status == ST_LIST_FULL))
        else $error("undefined status code");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

@@ dv/tb_first_fit_range_allocator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_range_allocator: directed and random requests
// checked against an in-bench prediction of the free list and bump cursor.
// Depends on ffra_pkg and the allocator RTL.
module tb_first_fit_range_allocator;
    import ffra_pkg::*;

    localparam int unsigned FREE_SLOTS = MAX_FREE_RANGES_DEF;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned IDLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned LIVE_SPANS_MAX = 64;
    localparam int unsigned PRINT_MAX = 40;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = 3'd0;

    typedef struct {
        logic [31:0] base;
        logic [31:0] len;
    } span_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ffra_req_t          request = '0;
    logic               result_valid;
    ffra_rsp_t          result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [31:0] list_base [FREE_SLOTS];
    logic [31:0] list_size [FREE_SLOTS];
    int unsigned list_used = 0;
    logic [31:0] cursor_next = '0;
    logic [31:0] capacity_now = '0;

    ffra_rsp_t   expected_grants [$];
    ffra_rsp_t   oldest_grant;
    span_t       live_spans [$];
    int unsigned error_count = 0;
    int unsigned printed = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    first_fit_range_allocator #(
        .MAX_FREE_RANGES(FREE_SLOTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result_valid(result_valid),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        error_count++;
        if (printed < PRINT_MAX)
        begin
            printed++;
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic ffra_rsp_t predict_grant(input ffra_req_t req);
        ffra_rsp_t   rsp;
        logic [32:0] st [FREE_SLOTS+1];
        logic [32:0] en [FREE_SLOTS+1];
        logic [32:0] span_len;
        int unsigned n;
        int unsigned w;
        bit          placed;
        rsp.granted_offset = '0;
        rsp.status = ST_OK;
        n = 0;
        w = 0;
        placed = 1'b0;
        if (req.unit_count == '0)
            return rsp;
        if (req.operation == OP_ALLOCATE)
        begin
            for (int i = 0; i < list_used; i++)
            begin
                if (list_size[i] >= req.unit_count)
                begin
                    rsp.granted_offset = list_base[i];
                    list_base[i] = list_base[i] + req.unit_count;
                    list_size[i] = list_size[i] - req.unit_count;
                    if (list_size[i] == '0)
                    begin
                        for (int j = i; j + 1 < list_used; j++)
                        begin
                            list_base[j] = list_base[j+1];
                            list_size[j] = list_size[j+1];
                        end
                        list_used--;
                    end
                    return rsp;
                end
            end
            if (cursor_next > capacity_now || req.unit_count > capacity_now - cursor_next)
            begin
                rsp.status = ST_NO_SPACE;
                return rsp;
            end
            rsp.granted_offset = cursor_next;
            cursor_next = cursor_next + req.unit_count;
            return rsp;
        end
        for (int i = 0; i < list_used; i++)
        begin
            if (!placed && list_base[i] > req.release_offset)
            begin
                st[n] = {1'b0, req.release_offset};
                en[n] = {1'b0, req.release_offset} + {1'b0, req.unit_count};
                n++;
                placed = 1'b1;
            end
            st[n] = {1'b0, list_base[i]};
            en[n] = {1'b0, list_base[i]} + {1'b0, list_size[i]};
            n++;
        end
        if (!placed)
        begin
            st[n] = {1'b0, req.release_offset};
            en[n] = {1'b0, req.release_offset} + {1'b0, req.unit_count};
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (w > 0 && en[w-1] >= st[i])
            begin
                if (en[i] > en[w-1])
                    en[w-1] = en[i];
            end
            else
            begin
                st[w] = st[i];
                en[w] = en[i];
                w++;
            end
        end
        if (w > FREE_SLOTS)
        begin
            rsp.status = ST_LIST_FULL;
            return rsp;
        end
        for (int i = 0; i < w; i++)
        begin
            span_len = en[i] - st[i];
            list_base[i] = st[i][31:0];
            list_size[i] = span_len[32] ? 32'hFFFF_FFFF : span_len[31:0];
        end
        list_used = w;
        return rsp;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_grants.size() == 0)
                report("result transfer with nothing expected");
            else
            begin
                oldest_grant = expected_grants.pop_front();
                if (result.granted_offset !== oldest_grant.granted_offset)
                    report($sformatf("granted_offset got %h expected %h",
                                     result.granted_offset, oldest_grant.granted_offset));
                if (result.status !== oldest_grant.status)
                    report($sformatf("status got %0d expected %0d",
                                     result.status, oldest_grant.status));
            end
        end
    end

    task automatic send_op(input logic op, input logic [31:0] count, input logic [31:0] offset);
        ffra_req_t item;
        ffra_rsp_t rsp;
        span_t     s;
        item.operation = op;
        item.unit_count = count;
        item.release_offset = offset;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy !== 1'b0);
        rsp = predict_grant(item);
        expected_grants = {expected_grants, rsp};
        if (op == OP_ALLOCATE && rsp.status == ST_OK && count != '0)
        begin
            s.base = rsp.granted_offset;
            s.len = count;
            live_spans = {live_spans, s};
            if (live_spans.size() > LIVE_SPANS_MAX)
                void'(live_spans.pop_front());
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        capacity_now = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== value)
            report($sformatf("capacity readback got %h expected %h", prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned idx;
        span_t       s;
        logic [31:0] cut;
        pick = $urandom_range(0, 99);
        if (pick >= 45 && pick < 88 && live_spans.size() == 0)
            pick = 0;
        if (pick < 40)
            send_op(OP_ALLOCATE, $urandom_range(1, 48), $urandom);
        else if (pick < 45)
            send_op(OP_ALLOCATE, $urandom_range(49, 1500), $urandom);
        else if (pick < 80)
        begin
            idx = $urandom_range(0, live_spans.size() - 1);
            s = live_spans[idx];
            cut = ($urandom_range(0, 1) == 0) ? s.len : $urandom_range(1, s.len);
            if (cut == s.len)
                live_spans.delete(idx);
            else
            begin
                live_spans[idx].base = s.base + cut;
                live_spans[idx].len = s.len - cut;
            end
            send_op(OP_RELEASE, cut, s.base);
        end
        else if (pick < 88)
        begin
            // overlap or double-free around a live range
            s = live_spans[$urandom_range(0, live_spans.size() - 1)];
            send_op(OP_RELEASE, $urandom_range(1, s.len + 4), s.base + $urandom_range(0, 8) - 4);
        end
        else if (pick < 96)
            send_op(1'($urandom_range(0, 1)), $urandom, $urandom);
        else
            send_op(1'($urandom_range(0, 1)), '0, $urandom);
    endtask

    task automatic run_traffic(input int unsigned items);
        repeat (items) send_random_item();
    endtask

    task automatic test_zero_requests();
        send_op(OP_ALLOCATE, '0, $urandom);
        send_op(OP_ALLOCATE, 32'd1, '0);
        send_op(OP_RELEASE, '0, 32'hFFFF_FFFF);
        send_op(OP_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_first_fit();
        write_capacity(32'd100);
        send_op(OP_ALLOCATE, 32'd10, '0);
        send_op(OP_ALLOCATE, 32'd20, '0);
        send_op(OP_ALLOCATE, 32'd70, '0);
        send_op(OP_ALLOCATE, 32'd1, '0);
        send_op(OP_RELEASE, 32'd10, 32'd10);
        send_op(OP_RELEASE, 32'd5, 32'd40);
        send_op(OP_ALLOCATE, 32'd6, '0);
        send_op(OP_ALLOCATE, 32'd4, '0);
        send_op(OP_RELEASE, 32'd3, 32'd40);
        send_op(OP_RELEASE, 32'd10, 32'd30);
        send_op(OP_ALLOCATE, 32'd15, '0);
    endtask

    task automatic test_top_of_space();
        write_capacity(32'hFFFF_FFFF);
        send_op(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_op(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_ALLOCATE, 32'hFFFF_FFFF, '0);
        send_op(OP_ALLOCATE, 32'h8000_0000, '0);
        send_op(OP_ALLOCATE, 32'h8000_0000, '0);
    endtask

    task automatic test_lowered_capacity();
        write_capacity(32'd50);
        send_op(OP_ALLOCATE, 32'd1, '0);
        send_op(OP_RELEASE, 32'd4, 32'd2);
        send_op(OP_ALLOCATE, 32'd4, '0);
        write_capacity('0);
        send_op(OP_ALLOCATE, '0, '0);
    endtask

    task automatic test_list_overflow();
        logic [31:0] base;
        logic [31:0] count;
        logic [31:0] first_end;
        logic [31:0] second_base;
        write_capacity(cursor_next);
        base = 32'hF000_0000 + $urandom_range(0, 32'h00FF_FFFF);
        first_end = '0;
        second_base = '0;
        for (int k = 0; k < FREE_SLOTS + 4; k++)
        begin
            count = $urandom_range(1, 8);
            if (k == 1)
                second_base = base;
            send_op(OP_RELEASE, count, base);
            if (k == 0)
                first_end = base + count;
            base = base + count + $urandom_range(1, 8);
        end
        // bridge the first two ranges so three entries merge into one
        send_op(OP_RELEASE, second_base - first_end, first_end);
        repeat (3) send_op(OP_ALLOCATE, $urandom_range(1, 8), $urandom);
    endtask

    task automatic test_steady_traffic();
        write_capacity(cursor_next + $urandom_range(1500, 3000));
        run_traffic(300);
    endtask

    task automatic test_exact_capacity();
        write_capacity(cursor_next);
        run_traffic(100);
    endtask

    task automatic test_tight_capacity();
        write_capacity((cursor_next > 32'hFFFF_F000) ? 32'hFFFF_FFFF
                                                     : cursor_next + $urandom_range(200, 600));
        run_traffic(150);
    endtask

    task automatic test_random_capacity();
        write_capacity($urandom);
        run_traffic(150);
    endtask

    task automatic test_full_space();
        write_capacity(32'hFFFF_FFFF);
        run_traffic(150);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_first_fit_range_allocator: errors");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_requests();
        test_first_fit();
        test_top_of_space();
        test_lowered_capacity();
        test_steady_traffic();
        test_list_overflow();
        test_exact_capacity();
        test_tight_capacity();
        test_random_capacity();
        test_full_space();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_grants.size() != 0)
            report("results still expected at end of run");
        if (error_count == 0)
            $display("tb_first_fit_range_allocator: clean");
        else
            $display("tb_first_fit_range_allocator: errors");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_range_allocator.sv
hw/rtl/ffra_checker.sv
dv/tb_first_fit_range_allocator.sv
